FILE: rtl/hcd_pkg.sv
// Shared types, codes and a helper function of the hall call dispatcher.
`default_nettype none

package hcd_pkg;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] REQ_ADD     = 2'd0;
    localparam logic [1:0] REQ_CLAIM   = 2'd1;
    localparam logic [1:0] REQ_UPDATE  = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // Result status codes carried on the output tuser.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOREQ   = 2'd1;
    localparam logic [1:0] ST_ALLDONE = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Stream widths.
    localparam int USER_W     = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int FLOOR_W    = 7;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_LOAD = 5'b00100,
        S_PICK = 5'b01000,
        S_FIN  = 5'b10000
    } hcd_state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec_commit;
        logic requeue;
        logic load_cand;
        logic load_pick;
        logic search_commit;
    } hcd_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic need_search;
        logic out_free;
    } hcd_stat_t;

    // A car at floor car can serve floor g within one move.
    function automatic logic hcd_reach(input logic [FLOOR_W-1:0] car, input logic dn,
                                       input logic stop, input logic [FLOOR_W-1:0] g);
        logic [FLOOR_W:0] c8;
        logic [FLOOR_W:0] g8;
        logic             r;
        c8 = {1'b0, car};
        g8 = {1'b0, g};
        if (stop)
        begin
            r = (c8 == g8) || (c8 + 1'b1 == g8) || (g8 + 1'b1 == c8);
        end
        else if (dn)
        begin
            r = (g8 + 1'b1 == c8);
        end
        else
        begin
            r = (c8 + 1'b1 == g8);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hall_call_dispatcher_core.sv
// Top level of the hall call dispatcher: sequencer plus datapath.
//
// Usage: one request beat enters on the s_ stream (kind in s_tuser), one result
// beat leaves on the m_ stream (status in m_tuser) for every request.
// Requests: add a hall call, claim a call, or update a car's target, which
// re-queues a reachable held claim and picks the next call in SCAN order.
// Timing: s_tready is high only while the sequencer is idle. Add, claim,
// invalid requests and updates that need no search commit their result from
// the execute state; updates that search step through execute, candidate
// load, priority encode and commit. A new request is accepted only once the
// sequencer is back in idle, so requests do not overlap.
// Reset clears all four call bitmaps and the result valid flag at once; no
// clearing pass is needed. If the receiver stalls, the result waits in the
// output register and the next request is still accepted; its result then
// waits in the sequencer until the output register frees.
`default_nettype none

module hall_call_dispatcher_core #(
    parameter int FLOORS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tuser: req_type[1:0]
    input  wire logic [hcd_pkg::USER_W-1:0]     s_tuser,
    // s_tdata: floor[6:0], go_down[7], is_stopping[8], held_floor[15:9],
    //          held_down[16], sources_done[17], zero[23:18]
    input  wire logic [hcd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tuser: status[1:0]
    output logic [hcd_pkg::USER_W-1:0]          m_tuser,
    // m_tdata: pick_floor[6:0], pick_down[7], claimed[8], zero[15:9]
    output logic [hcd_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import hcd_pkg::*;

    hcd_cmd_t  cmd;
    hcd_stat_t stat;

    // Sequencer.
    hcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Bitmaps, search and result register.
    hcd_datapath #(
        .FLOORS (FLOORS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

FILE: rtl/hcd_ctrl.sv
// Sequencer of the hall call dispatcher: steps each request through its cycles.
`default_nettype none

module hcd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire hcd_pkg::hcd_stat_t stat,
    output hcd_pkg::hcd_cmd_t      cmd
);
    import hcd_pkg::*;

    hcd_state_t state_reg;
    hcd_state_t state_next;

    // Next state: short requests and updates with no search finish in execute once the output is free; others search.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.need_search)
                    state_next = S_LOAD;
                else if (stat.out_free)
                    state_next = S_IDLE;
            end
            S_LOAD:  state_next = S_PICK;
            S_PICK:  state_next = S_FIN;
            S_FIN:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Commands to the datapath.
    assign s_tready          = (state_reg == S_IDLE);
    assign cmd.load_in       = s_tvalid && (state_reg == S_IDLE);
    assign cmd.exec_commit   = (state_reg == S_EXEC) && !stat.need_search && stat.out_free;
    assign cmd.requeue       = (state_reg == S_EXEC) && stat.need_search;
    assign cmd.load_cand     = (state_reg == S_LOAD);
    assign cmd.load_pick     = (state_reg == S_PICK);
    assign cmd.search_commit = (state_reg == S_FIN) && stat.out_free;

    // An accepted beat always goes to the execute cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_EXEC)
        else $error("accepted beat did not enter execute");

    // The final search cycle is only reached from the encode cycle or by waiting.
    a_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |-> $past(state_reg) == S_PICK || $past(state_reg) == S_FIN)
        else $error("search finish out of order");

endmodule

`default_nettype wire

FILE: rtl/hcd_datapath.sv
// Datapath of the hall call dispatcher: call bitmaps, SCAN search and result register.
`default_nettype none

module hcd_datapath #(
    parameter int FLOORS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [hcd_pkg::USER_W-1:0]     s_tuser,
    input  wire logic [hcd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [hcd_pkg::USER_W-1:0]          m_tuser,
    output logic [hcd_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire hcd_pkg::hcd_cmd_t              cmd,
    output hcd_pkg::hcd_stat_t                  stat
);
    import hcd_pkg::*;

    localparam int FW = $clog2(FLOORS);
    localparam int KW = 2 * FLOORS;
    localparam int IW = $clog2(KW);
    localparam logic [FLOOR_W-1:0] FLOORS_F = FLOOR_W'(FLOORS);

    // Captured request.
    logic [1:0]         req_reg;
    logic [FLOOR_W-1:0] floor_reg;
    logic               down_reg;
    logic               stop_reg;
    logic [FLOOR_W-1:0] held_reg;
    logic               held_dn_reg;
    logic               done_reg;

    // Call bitmaps, bit f-1 for floor f.
    logic [FLOORS-1:0] up_pend_reg, up_pend_next;
    logic [FLOORS-1:0] dn_pend_reg, dn_pend_next;
    logic [FLOORS-1:0] up_int_reg, up_int_next;
    logic [FLOORS-1:0] dn_int_reg, dn_int_next;

    // Search candidates in key order and the encoded pick.
    logic [KW-1:0]      cand_all_reg, cand_all_next;
    logic [KW-1:0]      cand_hit_reg, cand_hit_next;
    logic               pick_found_reg;
    logic [FLOOR_W-1:0] pick_floor_reg;
    logic               pick_down_reg;

    // Result register.
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [FLOOR_W-1:0] out_floor_reg;
    logic               out_down_reg;
    logic               out_claimed_reg;

    logic               floor_ok, held_ok, held_int, held_reach;
    logic               in_int, in_pend, pend_any, int_any;
    logic [FW-1:0]      fidx, hidx, pidx;
    logic [1:0]         ex_status;
    logic [FLOOR_W-1:0] ex_floor;
    logic               ex_down, ex_claimed, need_search;
    logic signed [8:0]  srch_key;
    logic signed [8:0]  car9;
    logic [KW-1:0]      sel;
    logic [IW-1:0]      enc_idx;
    logic [FLOOR_W:0]   enc_floor;
    logic               pick_adj;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg     <= s_tuser;
            floor_reg   <= s_tdata[6:0];
            down_reg    <= s_tdata[7];
            stop_reg    <= s_tdata[8];
            held_reg    <= s_tdata[15:9];
            held_dn_reg <= s_tdata[16];
            done_reg    <= s_tdata[17];
        end
    end

    // Lookups on the bitmaps for the request and the held target.
    assign floor_ok   = (floor_reg != '0) && (floor_reg <= FLOORS_F);
    assign held_ok    = (held_reg != '0) && (held_reg <= FLOORS_F);
    assign fidx       = FW'(floor_reg - 1'b1);
    assign hidx       = FW'(held_reg - 1'b1);
    assign pidx       = FW'(pick_floor_reg - 1'b1);
    assign in_int     = floor_ok && (down_reg ? dn_int_reg[fidx] : up_int_reg[fidx]);
    assign in_pend    = floor_ok && (down_reg ? dn_pend_reg[fidx] : up_pend_reg[fidx]);
    assign pend_any   = (|up_pend_reg) || (|dn_pend_reg);
    assign int_any    = (|up_int_reg) || (|dn_int_reg);
    assign held_int   = held_ok && (held_dn_reg ? dn_int_reg[hidx] : up_int_reg[hidx]);
    assign held_reach = hcd_reach(floor_reg, down_reg, stop_reg, held_reg);
    assign pick_adj   = hcd_reach(floor_reg, down_reg, stop_reg, pick_floor_reg);

    // Decision of the execute cycle.
    always_comb
    begin
        ex_status   = ST_OK;
        ex_floor    = '0;
        ex_down     = 1'b0;
        ex_claimed  = 1'b0;
        need_search = 1'b0;
        case (req_reg)
            REQ_ADD:
            begin
                if (!floor_ok)
                    ex_status = ST_NOREQ;
            end
            REQ_CLAIM:
            begin
                if (!floor_ok)
                begin
                    ex_status = ST_NOREQ;
                end
                else if (in_int || in_pend)
                begin
                    ex_floor   = floor_reg;
                    ex_down    = down_reg;
                    ex_claimed = 1'b1;
                end
            end
            REQ_UPDATE:
            begin
                if (done_reg && !pend_any && !int_any)
                begin
                    ex_status = ST_ALLDONE;
                end
                else if (held_int)
                begin
                    if (held_reach)
                    begin
                        need_search = 1'b1;
                    end
                    else
                    begin
                        ex_floor = held_reg;
                        ex_down  = held_dn_reg;
                    end
                end
                else if (stop_reg && !pend_any)
                begin
                    ex_status = ST_EMPTY;
                end
                else
                begin
                    need_search = 1'b1;
                end
            end
            default: ex_status = ST_NOREQ;
        endcase
    end

    // Bitmap updates at the commit points.
    always_comb
    begin
        up_pend_next = up_pend_reg;
        dn_pend_next = dn_pend_reg;
        up_int_next  = up_int_reg;
        dn_int_next  = dn_int_reg;
        if (cmd.exec_commit && floor_ok)
        begin
            if (req_reg == REQ_ADD)
            begin
                if (down_reg)
                    dn_pend_next[fidx] = 1'b1;
                else
                    up_pend_next[fidx] = 1'b1;
            end
            else if (req_reg == REQ_CLAIM)
            begin
                if (in_int)
                begin
                    if (down_reg)
                        dn_int_next[fidx] = 1'b0;
                    else
                        up_int_next[fidx] = 1'b0;
                end
                else if (down_reg)
                begin
                    dn_pend_next[fidx] = 1'b0;
                end
                else
                begin
                    up_pend_next[fidx] = 1'b0;
                end
            end
        end
        if (cmd.requeue && held_int && held_reach)
        begin
            if (held_dn_reg)
            begin
                dn_int_next[hidx]  = 1'b0;
                dn_pend_next[hidx] = 1'b1;
            end
            else
            begin
                up_int_next[hidx]  = 1'b0;
                up_pend_next[hidx] = 1'b1;
            end
        end
        // The pick leaves pending; it is claimed as intended unless served at once,
        // in which case any earlier claim on the same call is dropped too.
        if (cmd.search_commit && pick_found_reg)
        begin
            if (pick_down_reg)
            begin
                dn_pend_next[pidx] = 1'b0;
                dn_int_next[pidx]  = !pick_adj;
            end
            else
            begin
                up_pend_next[pidx] = 1'b0;
                up_int_next[pidx]  = !pick_adj;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_pend_reg <= '0;
            dn_pend_reg <= '0;
            up_int_reg  <= '0;
            dn_int_reg  <= '0;
        end
        else
        begin
            up_pend_reg <= up_pend_next;
            dn_pend_reg <= dn_pend_next;
            up_int_reg  <= up_int_next;
            dn_int_reg  <= dn_int_next;
        end
    end

    // Signed search key: the car floor, or the next floor when moving, negated going down.
    assign car9 = signed'({2'b00, floor_reg});
    always_comb
    begin
        if (stop_reg)
            srch_key = down_reg ? -car9 : car9;
        else
            srch_key = down_reg ? (9'sd1 - car9) : (car9 + 9'sd1);
    end

    // Candidate vectors: down calls from the top floor, then up calls from the bottom.
    always_comb
    begin
        cand_all_next = '0;
        cand_hit_next = '0;
        for (int i = 0; i < FLOORS; i++)
        begin
            cand_all_next[i] = dn_pend_reg[FLOORS-1-i];
            cand_hit_next[i] = cand_all_next[i] && ((i - FLOORS) >= int'(srch_key));
        end
        for (int i = 0; i < FLOORS; i++)
        begin
            cand_all_next[FLOORS+i] = up_pend_reg[i];
            cand_hit_next[FLOORS+i] = cand_all_next[FLOORS+i] && ((i + 1) >= int'(srch_key));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_cand)
        begin
            cand_all_reg <= cand_all_next;
            cand_hit_reg <= cand_hit_next;
        end
    end

    // First candidate at or after the key, else the first candidate overall.
    assign sel = (|cand_hit_reg) ? cand_hit_reg : cand_all_reg;
    always_comb
    begin
        enc_idx = '0;
        for (int i = KW - 1; i >= 0; i--)
        begin
            if (sel[i])
                enc_idx = IW'(i);
        end
    end
    assign enc_floor = ({1'b0, enc_idx} < (IW+1)'(FLOORS))
                     ? ((FLOOR_W+1)'(FLOORS) - (FLOOR_W+1)'(enc_idx))
                     : ((FLOOR_W+1)'(enc_idx) - (FLOOR_W+1)'(FLOORS) + 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_pick)
        begin
            pick_found_reg <= |sel;
            pick_floor_reg <= enc_floor[FLOOR_W-1:0];
            pick_down_reg  <= ({1'b0, enc_idx} < (IW+1)'(FLOORS));
        end
    end

    // Result register: takes a new result whenever the old one is gone or leaving.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.exec_commit || cmd.search_commit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_commit)
        begin
            out_status_reg  <= ex_status;
            out_floor_reg   <= ex_floor;
            out_down_reg    <= ex_down;
            out_claimed_reg <= ex_claimed;
        end
        else if (cmd.search_commit)
        begin
            out_status_reg  <= pick_found_reg ? ST_OK : ST_NOREQ;
            out_floor_reg   <= pick_found_reg ? pick_floor_reg : '0;
            out_down_reg    <= pick_found_reg && pick_down_reg;
            out_claimed_reg <= pick_found_reg && pick_adj;
        end
    end

    assign stat.need_search = need_search;
    assign stat.out_free    = !out_valid_reg || m_tready;
    assign m_tvalid         = out_valid_reg;
    assign m_tuser          = out_status_reg;
    assign m_tdata          = {7'b0, out_claimed_reg, out_down_reg, out_floor_reg};

    // A result that is not ok carries no pick and no claim.
    a_noreq_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[8:0] == '0)
        else $error("non-ok result carries a pick");

    // A result's floor never lies beyond the top floor.
    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:0] <= FLOORS_F)
        else $error("pick floor beyond the building");

endmodule

`default_nettype wire

FILE: tb/tb_hall_call_dispatcher_core.sv
// Self-checking testbench for the hall call dispatcher core with a SCAN-order call book.
`timescale 1ns / 100ps

module tb_hall_call_dispatcher_core;

    import hcd_pkg::*;

    localparam int FLOORS          = 32;
    localparam int PENDING         = 0;
    localparam int INTENDED        = 1;
    localparam int DIR_UP          = 0;
    localparam int DIR_DOWN        = 1;
    localparam int CARS            = 2;
    localparam int PHASES          = 3;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 20;

    // One result beat, split into its fields.
    typedef struct packed {
        logic [1:0] status;
        logic [6:0] pick_floor;
        logic       pick_down;
        logic       claimed;
    } dispatch_result_t;

    // Call book: mirrors the pending and claimed call maps and predicts each answer.
    class hall_call_book;
        bit               call_map[2][2][FLOORS+1];
        dispatch_result_t answer_q[$];
        dispatch_result_t last_answer;
        int               failures;
        int               status_seen[4];
        int               kind_seen[4];
        int               removals;

        function new();
            foreach (call_map[l, d, f])
            begin
                call_map[l][d][f] = 1'b0;
            end
            failures = 0;
            removals = 0;
            foreach (status_seen[i])
            begin
                status_seen[i] = 0;
                kind_seen[i]   = 0;
            end
        endfunction

        function int floor_of(int key);
            return key < 0 ? -key : key;
        endfunction

        function int dir_of(int key);
            return key < 0 ? DIR_DOWN : DIR_UP;
        endfunction

        function bit has_key(int list, int key);
            int f;
            f = floor_of(key);
            if (f < 1 || f > FLOORS)
            begin
                return 1'b0;
            end
            return call_map[list][dir_of(key)][f];
        endfunction

        function void put_key(int list, int key, bit v);
            int f;
            f = floor_of(key);
            if (f >= 1 && f <= FLOORS)
            begin
                call_map[list][dir_of(key)][f] = v;
            end
        endfunction

        function bit any_in(int list);
            for (int f = 1; f <= FLOORS; f++)
            begin
                if (call_map[list][DIR_UP][f] || call_map[list][DIR_DOWN][f])
                begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Takes the first pending key at or after the search key, wrapping to the
        // first pending key, and moves it to the claimed map. Zero means none.
        function int pop_nearest(int search);
            int key;
            int first;
            int hit;
            first = 0;
            hit   = 0;
            for (int i = 0; i < 2 * FLOORS && hit == 0; i++)
            begin
                key = (i < FLOORS) ? -(FLOORS - i) : (i - FLOORS + 1);
                if (has_key(PENDING, key))
                begin
                    if (first == 0)
                    begin
                        first = key;
                    end
                    if (key >= search)
                    begin
                        hit = key;
                    end
                end
            end
            if (hit == 0)
            begin
                hit = first;
            end
            if (hit != 0)
            begin
                put_key(PENDING, hit, 1'b0);
                put_key(INTENDED, hit, 1'b1);
            end
            return hit;
        endfunction

        // A claimed entry is removed in preference to a pending one.
        function bit erase_key(int key);
            if (has_key(INTENDED, key))
            begin
                put_key(INTENDED, key, 1'b0);
                return 1'b1;
            end
            if (has_key(PENDING, key))
            begin
                put_key(PENDING, key, 1'b0);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit in_reach(int car, int step, bit stop, int key);
            int g;
            g = floor_of(key);
            if (stop)
            begin
                return (car - g >= -1) && (car - g <= 1);
            end
            return car + step == g;
        endfunction

        function dispatch_result_t make_result(logic [1:0] st, int key, bit cl);
            dispatch_result_t r;
            r.status     = st;
            r.pick_floor = 7'(floor_of(key));
            r.pick_down  = key < 0;
            r.claimed    = cl;
            return r;
        endfunction

        function dispatch_result_t predict(logic [1:0] kind, logic [23:0] payload);
            int car;
            int held;
            int step;
            int key;
            int hk;
            int pick;
            bit dn;
            bit stop;
            bit hdown;
            bit done;
            bit cl;
            car   = int'(payload[6:0]);
            dn    = payload[7];
            stop  = payload[8];
            held  = int'(payload[15:9]);
            hdown = payload[16];
            done  = payload[17];
            step  = dn ? -1 : 1;
            key   = dn ? -car : car;

            if (kind == REQ_ADD || kind == REQ_CLAIM)
            begin
                if (car < 1 || car > FLOORS)
                begin
                    return make_result(ST_NOREQ, 0, 1'b0);
                end
                if (kind == REQ_ADD)
                begin
                    put_key(PENDING, key, 1'b1);
                    return make_result(ST_OK, 0, 1'b0);
                end
                if (erase_key(key))
                begin
                    return make_result(ST_OK, key, 1'b1);
                end
                return make_result(ST_OK, 0, 1'b0);
            end
            if (kind != REQ_UPDATE)
            begin
                return make_result(ST_NOREQ, 0, 1'b0);
            end

            // Car target update.
            if (done && !any_in(PENDING) && !any_in(INTENDED))
            begin
                return make_result(ST_ALLDONE, 0, 1'b0);
            end
            hk = (held >= 1 && held <= FLOORS) ? (hdown ? -held : held) : 0;
            if (hk != 0 && has_key(INTENDED, hk))
            begin
                if (in_reach(car, step, stop, hk))
                begin
                    put_key(INTENDED, hk, 1'b0);
                    put_key(PENDING, hk, 1'b1);
                    pick = pop_nearest(stop ? car * step : (car + step) * step);
                end
                else
                begin
                    pick = hk;
                end
            end
            else if (stop)
            begin
                if (!any_in(PENDING))
                begin
                    return make_result(ST_EMPTY, 0, 1'b0);
                end
                pick = pop_nearest(car * step);
            end
            else
            begin
                pick = pop_nearest((car + step) * step);
            end
            if (pick == 0)
            begin
                return make_result(ST_NOREQ, 0, 1'b0);
            end
            cl = 1'b0;
            if (in_reach(car, step, stop, pick))
            begin
                cl = erase_key(pick);
            end
            return make_result(ST_OK, pick, cl);
        endfunction

        function void note_request(logic [1:0] kind, logic [23:0] payload);
            last_answer = predict(kind, payload);
            answer_q.push_back(last_answer);
            kind_seen[kind]++;
            status_seen[last_answer.status]++;
            if (last_answer.claimed)
            begin
                removals++;
            end
        endfunction

        function void check_result(logic [1:0] st, logic [15:0] data);
            dispatch_result_t want;
            dispatch_result_t got;
            got = {st, data[6:0], data[7], data[8]};
            if (answer_q.size() == 0)
            begin
                $error("result beat arrived with no request outstanding");
                failures++;
                return;
            end
            want = answer_q.pop_front();
            if (got.status != want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.pick_floor != want.pick_floor)
            begin
                $error("pick_floor mismatch: expected %0d, actual %0d",
                       want.pick_floor, got.pick_floor);
                failures++;
            end
            if (got.pick_down != want.pick_down)
            begin
                $error("pick_down mismatch: expected %0d, actual %0d",
                       want.pick_down, got.pick_down);
                failures++;
            end
            if (got.claimed != want.claimed)
            begin
                $error("claimed mismatch: expected %0d, actual %0d", want.claimed, got.claimed);
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [15:0] m_tdata;

    hall_call_book book;
    int            burst_left;
    int            idle_cycles = 0;
    int            stall_mode  = 0;
    int            mode_left   = 0;
    int            pattern_tick = 0;

    // Simulated cars that follow the targets they are given.
    int car_floor[CARS];
    bit car_down[CARS];
    int held_floor[CARS];
    bit held_down[CARS];

    hall_call_dispatcher_core #(
        .FLOORS(FLOORS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser(m_tuser),
        .m_tdata(m_tdata)
    );

    // 125 MHz clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result checking, stall pattern of the receiver and the idle watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                book.check_result(m_tuser, m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        pattern_tick++;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (pattern_tick % 4) != 3;
            default: m_tready <= ((pattern_tick / 8) % 2) == 0;
        endcase
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("hall_call_dispatcher_core verification failed");
            $finish;
        end
    end

    function automatic logic [23:0] pack_request(int fl, bit dn, bit stop, int held,
                                                 bit hdown, bit done);
        logic [6:0] f7;
        logic [6:0] h7;
        f7 = 7'(fl);
        h7 = 7'(held);
        return {6'b0, done, hdown, h7, stop, dn, f7};
    endfunction

    // Sends one request beat; the sender pauses between bursts of random length.
    task automatic send_beat(input logic [1:0] kind, input logic [23:0] payload);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        book.note_request(kind, payload);
    endtask

    task automatic send_call(input logic [1:0] kind, input int fl, input bit dn);
        send_beat(kind, pack_request(fl, dn, 1'b0, 0, 1'b0, 1'b0));
    endtask

    task automatic send_update(input int fl, input bit dn, input bit stop, input int held,
                               input bit hdown, input bit done);
        send_beat(REQ_UPDATE, pack_request(fl, dn, stop, held, hdown, done));
    endtask

    // One car asks for its next target, then moves a floor toward it, or onward when it has none and is not stopped.
    task automatic car_update(input int c, input bit done);
        dispatch_result_t ans;
        bit               stop;
        int               hf;
        bit               hd;
        stop = ($urandom_range(0, 3) == 0) ||
               (held_floor[c] != 0 && held_floor[c] == car_floor[c]);
        hf = held_floor[c];
        hd = held_down[c];
        if ($urandom_range(0, 9) == 0)
        begin
            hf = $urandom_range(0, 127);
            hd = 1'($urandom_range(0, 1));
        end
        send_update(car_floor[c], car_down[c], stop, hf, hd, done);
        ans = book.last_answer;
        if (ans.status == ST_OK && !ans.claimed)
        begin
            held_floor[c] = int'(ans.pick_floor);
            held_down[c]  = ans.pick_down;
        end
        else
        begin
            held_floor[c] = 0;
        end
        if (held_floor[c] != 0)
        begin
            if (car_floor[c] < held_floor[c])
            begin
                car_floor[c]++;
                car_down[c] = 1'b0;
            end
            else if (car_floor[c] > held_floor[c])
            begin
                car_floor[c]--;
                car_down[c] = 1'b1;
            end
        end
        else if (!stop)
        begin
            if (car_floor[c] <= 1)
            begin
                car_down[c] = 1'b0;
            end
            else if (car_floor[c] >= FLOORS)
            begin
                car_down[c] = 1'b1;
            end
            car_floor[c] += car_down[c] ? -1 : 1;
        end
    endtask

    // Directed cases: empty-map answers, range limits, SCAN order, held claims.
    task automatic run_directed();
        send_update(5, 1'b0, 1'b0, 0, 1'b0, 1'b1);
        send_update(5, 1'b0, 1'b1, 0, 1'b0, 1'b0);
        send_update(5, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        send_call(REQ_ADD, 0, 1'b0);
        send_call(REQ_ADD, FLOORS + 1, 1'b1);
        send_call(REQ_CLAIM, 127, 1'b1);
        send_beat(REQ_UNKNOWN, {6'b0, 18'h3FFFF});
        send_call(REQ_ADD, 1, 1'b0);
        send_call(REQ_ADD, FLOORS, 1'b1);
        send_call(REQ_ADD, FLOORS, 1'b0);
        send_call(REQ_ADD, 1, 1'b1);
        send_call(REQ_ADD, 16, 1'b0);
        send_call(REQ_ADD, 17, 1'b1);
        send_call(REQ_CLAIM, 16, 1'b0);
        send_call(REQ_CLAIM, 16, 1'b0);
        send_update(10, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        send_update(FLOORS - 1, 1'b0, 1'b0, FLOORS, 1'b0, 1'b0);
        send_update(20, 1'b1, 1'b0, 0, 1'b0, 1'b1);
        send_update(25, 1'b1, 1'b1, 17, 1'b1, 1'b0);
        send_update(0, 1'b1, 1'b1, 100, 1'b1, 1'b0);
        send_update(127, 1'b0, 1'b0, 64, 1'b1, 1'b0);
        send_call(REQ_CLAIM, FLOORS, 1'b1);
        send_call(REQ_CLAIM, 17, 1'b1);
        send_call(REQ_CLAIM, 1, 1'b1);
        send_update(3, 1'b0, 1'b0, 0, 1'b0, 1'b1);
    endtask

    // Mostly adds, claims and car updates, with some raw noise beats.
    task automatic run_random_phase();
        int          count;
        int          pick;
        int          fl;
        int          tries;
        bit          dn;
        logic [31:0] noise;
        count = 0;
        while (count < ITEMS_PER_PHASE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                fl = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(1, FLOORS);
                send_call(REQ_ADD, fl, 1'($urandom_range(0, 1)));
                count++;
            end
            else if (pick < 47)
            begin
                fl    = $urandom_range(1, FLOORS);
                dn    = 1'($urandom_range(0, 1));
                tries = 0;
                while ($urandom_range(0, 1) && tries < 16 &&
                       !book.call_map[PENDING][dn][fl] && !book.call_map[INTENDED][dn][fl])
                begin
                    fl = $urandom_range(1, FLOORS);
                    dn = 1'($urandom_range(0, 1));
                    tries++;
                end
                send_call(REQ_CLAIM, fl, dn);
                count++;
            end
            else if (pick < 93)
            begin
                car_update($urandom_range(0, CARS - 1), $urandom_range(0, 3) == 0);
                count++;
            end
            else
            begin
                noise = $urandom;
                send_beat(noise[31:30], {6'b0, noise[17:0]});
            end
        end
    endtask

    // Sends a claim for every remaining call entry, then gives each car an update marked done.
    task automatic drain_calls();
        for (int l = 0; l < 2; l++)
        begin
            for (int d = 0; d < 2; d++)
            begin
                for (int f = 1; f <= FLOORS; f++)
                begin
                    if (book.call_map[l][d][f])
                    begin
                        send_call(REQ_CLAIM, f, d == DIR_DOWN);
                    end
                end
            end
        end
        for (int c = 0; c < CARS; c++)
        begin
            car_update(c, 1'b1);
        end
    endtask

    initial
    begin
        book       = new();
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = '0;
        s_tdata    = '0;
        burst_left = 0;
        for (int c = 0; c < CARS; c++)
        begin
            car_floor[c]  = $urandom_range(1, FLOORS);
            car_down[c]   = 1'($urandom_range(0, 1));
            held_floor[c] = 0;
            held_down[c]  = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            run_random_phase();
            drain_calls();
        end
        s_tvalid <= 1'b0;

        // Let the outstanding results drain, then wait out the settle period.
        while (book.answer_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d adds, %0d claims, %0d updates, %0d unknown kinds; %0d removals.",
                 book.kind_seen[REQ_ADD], book.kind_seen[REQ_CLAIM],
                 book.kind_seen[REQ_UPDATE], book.kind_seen[REQ_UNKNOWN], book.removals);
        $display("Answers seen: %0d ok, %0d no request, %0d all done, %0d empty.",
                 book.status_seen[ST_OK], book.status_seen[ST_NOREQ],
                 book.status_seen[ST_ALLDONE], book.status_seen[ST_EMPTY]);
        if (book.failures == 0 && book.answer_q.size() == 0)
        begin
            $display("hall_call_dispatcher_core verification clean");
        end
        else
        begin
            $display("hall_call_dispatcher_core verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/hcd_pkg.sv
rtl/hcd_ctrl.sv
rtl/hcd_datapath.sv
rtl/hall_call_dispatcher_core.sv
tb/tb_hall_call_dispatcher_core.sv
